### rtl/bsd160_pkg.sv
// ----------------------------------------------------------------------------
// bsd160_pkg
// Shared types and constants for the 160-bit byte stream digest.
// ----------------------------------------------------------------------------
package bsd160_pkg;

  // Number of mixing words in the digest state.
  localparam int unsigned NUM_WORDS = 5;

  // Rotate-and-XOR steps in finalization: three rounds over all words.
  localparam int unsigned ROUND_STEPS = 3 * NUM_WORDS;

  // Largest byte count that still gives a reliable digest.
  localparam logic [31:0] LEN_LIMIT = 32'h7FFF_FFFF;

  // Starting values of the mixing words.
  localparam logic [31:0] INIT_WORDS [NUM_WORDS] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_ADD  = 1'b0,
    ALU_ROTX = 1'b1
  } alu_op_t;

endpackage

### rtl/bsd160_alu.sv
// ----------------------------------------------------------------------------
// bsd160_alu
// Shared 32-bit unit: modular add, or rotate-left-11 of one operand XORed
// with the other.
// ----------------------------------------------------------------------------
module bsd160_alu import bsd160_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  // Select the operation; the add wraps modulo 2^32.
  always_comb begin
    case (op)
      ALU_ADD:  y = a + b;
      ALU_ROTX: y = {a[20:0], a[31:21]} ^ b;
      default:  y = a + b;
    endcase
  end

endmodule

### rtl/byte_stream_digest_160_unit.sv
// ----------------------------------------------------------------------------
// byte_stream_digest_160_unit
// Byte-serial 160-bit message digest with a shared add/rotate unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one transaction per message byte (has_byte set),
//   and end_of_message marks the last one; an end marker may come with
//   has_byte clear, which also digests an empty message.
//   A byte keeps the input stalled after it is taken: the block first forms
//   the 8x32 position product, then makes three passes through the shared
//   32-bit adder, and it takes no new byte until these are done.
//   An end marker adds length folding and the rotate-XOR steps, all through
//   the same shared unit, then presents five output transactions,
//   word_index 0 to 4, last_word on the fifth.
//   The output words are held while out_stall is high; the input stays
//   stalled until the fifth word is taken, after which the state returns to
//   its starting values and a new message may begin.
//   too_long is set on all five words when the message exceeded
//   2147483647 bytes.
//   A synchronous reset loads the starting words, clears the byte count and
//   the overflow flag, and discards any digest in progress.
// ----------------------------------------------------------------------------
module byte_stream_digest_160_unit import bsd160_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        too_long
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_ADD1  = 9'b000000100,
    ST_MIX   = 9'b000001000,
    ST_SHIFT = 9'b000010000,
    ST_LEN0  = 9'b000100000,
    ST_LEN1  = 9'b001000000,
    ST_ROUND = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'(ROUND_STEPS - 1);
  localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

  state_t      state;
  logic [31:0] w [NUM_WORDS];
  logic [31:0] byte_count;
  logic        overflow_seen;
  logic [7:0]  byte_reg;
  logic        eom_reg;
  logic [31:0] prod;
  logic [3:0]  round_cnt;
  logic [2:0]  word_cnt;
  logic [31:0] byte_ext;
  logic [31:0] byte_rep;
  logic [31:0] rot7_w3;
  logic        in_take;
  logic        out_take;
  alu_op_t     alu_op;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [31:0] alu_y;
  logic [7:0]  fix0;
  logic [7:0]  fix1;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign byte_ext = {24'd0, byte_reg};
  assign byte_rep = {4{byte_reg}};
  assign rot7_w3  = {w[3][24:0], w[3][31:25]};

  // Operand selection for the shared unit, one use per sequencer step.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = w[1];
    alu_b  = prod;
    case (state)
      ST_ADD1: begin
        alu_a = w[1];
        alu_b = prod;
      end
      ST_MIX: begin
        alu_a = w[1];
        alu_b = byte_ext;
      end
      ST_SHIFT: begin
        alu_a = w[4];
        alu_b = w[0] ^ w[2];
      end
      ST_LEN0: begin
        alu_a = w[1];
        alu_b = {byte_count[23:0], 8'd0};
      end
      ST_LEN1: begin
        alu_a = w[3];
        alu_b = {byte_count[7:0], 24'd0};
      end
      ST_ROUND: begin
        alu_op = ALU_ROTX;
        alu_a  = w[0];
        alu_b  = w[1];
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  bsd160_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Sequencer and digest state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      round_cnt     <= '0;
      word_cnt      <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        w[i] <= INIT_WORDS[i];
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            byte_reg <= data_byte;
            eom_reg  <= end_of_message;
            if (has_byte) begin
              if (byte_count >= LEN_LIMIT) begin
                overflow_seen <= 1'b1;
              end
              state <= ST_MUL;
            end else if (end_of_message) begin
              state <= ST_LEN0;
            end
          end
        end
        ST_MUL: begin
          prod       <= byte_ext * (byte_count + 32'd1);
          byte_count <= byte_count + 32'd1;
          state      <= ST_ADD1;
        end
        ST_ADD1: begin
          w[1]  <= alu_y;
          state <= ST_MIX;
        end
        ST_MIX: begin
          w[0]  <= w[0] ^ byte_rep;
          w[2]  <= w[2] ^ alu_y;
          w[3]  <= rot7_w3;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          // Add into word 4, then shift the bank down by one word.
          w[0]  <= w[1];
          w[1]  <= w[2];
          w[2]  <= w[3];
          w[3]  <= alu_y;
          w[4]  <= w[0] ^ w[3] ^ byte_ext;
          state <= eom_reg ? ST_LEN0 : ST_IDLE;
        end
        ST_LEN0: begin
          w[0]  <= w[0] ^ byte_count;
          w[1]  <= alu_y;
          w[2]  <= w[2] ^ {byte_count[15:0], 16'd0};
          w[4]  <= w[4] ^ byte_count;
          state <= ST_LEN1;
        end
        ST_LEN1: begin
          w[3]      <= alu_y;
          round_cnt <= '0;
          state     <= ST_ROUND;
        end
        ST_ROUND: begin
          // Update the head word and rotate the bank; 15 steps restore order.
          w[0]      <= w[1];
          w[1]      <= w[2];
          w[2]      <= w[3];
          w[3]      <= w[4];
          w[4]      <= alu_y;
          round_cnt <= round_cnt + 4'd1;
          if (round_cnt == LAST_STEP) begin
            word_cnt <= '0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_take) begin
            word_cnt <= word_cnt + 3'd1;
            if (word_cnt == LAST_WORD) begin
              // Last word taken: return to the starting state.
              for (int i = 0; i < NUM_WORDS; i++) begin
                w[i] <= INIT_WORDS[i];
              end
              byte_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              w[0] <= w[1];
              w[1] <= w[2];
              w[2] <= w[3];
              w[3] <= w[4];
              w[4] <= w[0];
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Fixups for the first two digest bytes, taken while the bank is in order.
  assign fix0 = w[1][7:0] ^ w[3][7:0] ^ w[4][7:0];
  assign fix1 = w[2][31:24] ^ w[3][15:8] ^ w[4][15:8];

  // Output channel driven straight from the word bank.
  assign in_stall    = (state != ST_IDLE);
  assign out_valid   = (state == ST_EMIT);
  assign word_index  = word_cnt;
  assign last_word   = (word_cnt == LAST_WORD);
  assign too_long    = overflow_seen;
  assign digest_word = (word_cnt == 3'd0) ? (w[0] ^ {fix0, fix1, 16'd0}) : w[0];

  // The digest word index never passes the last word.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index <= LAST_WORD))
    else $error("digest word index out of range");

  // Input is never taken while a digest is being presented.
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while digest pending");

  // A digest always starts at word zero.
  a_emit_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest did not start at word zero");

  // Taking the last word returns the block to idle with a cleared count.
  a_last_word_resets: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_word) |=> (!out_valid && !in_stall && byte_count == 32'd0))
    else $error("state not restored after last digest word");

endmodule

### tb/byte_stream_digest_160_unit_tb.sv
// ----------------------------------------------------------------------------
// byte_stream_digest_160_unit_tb
// Self-checking bench for the byte-serial 160-bit message digest.
// Messages go in one byte per transaction. A scoreboard class follows the
// mixing words and the byte count, so it knows the five digest words that
// each end marker must produce. Every output transaction is checked in order.
// Both channels idle at random, and one long output hold-off backs the block
// up until it stalls its input.
// ----------------------------------------------------------------------------
module byte_stream_digest_160_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsd160_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int TOTAL_ITEMS  = 130;
  localparam int MAX_WAIT     = 17;

  // Tracks the digest state and the digest words still owed by the block.
  class digest_scoreboard;
    typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
      logic        overlong;
    } digest_out_t;

    logic [31:0] mix [NUM_WORDS];
    logic [31:0] bytes_taken;
    logic        length_overflow;
    digest_out_t owed_words [$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      int k;
      for (k = 0; k < NUM_WORDS; k++) mix[k] = INIT_WORDS[k];
      bytes_taken = '0;
      length_overflow = 1'b0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // Folds one message byte into the five words, then shifts them down.
    function void mix_byte(logic [7:0] b);
      logic [31:0] bw;
      logic [31:0] pos;
      logic [31:0] held;
      bw = {24'd0, b};
      pos = bytes_taken + 32'd1;
      mix[0] = mix[0] ^ {4{b}};
      mix[1] = mix[1] + bw * pos;
      mix[2] = mix[2] ^ (mix[1] + bw);
      mix[3] = rotl(mix[3], 7);
      mix[4] = mix[4] + (mix[0] ^ mix[2]);
      held = mix[0];
      mix[0] = mix[1];
      mix[1] = mix[2];
      mix[2] = mix[3];
      mix[3] = mix[4];
      mix[4] = held ^ mix[2] ^ bw;
    endfunction

    // Notes an accepted input transaction; an end marker queues five words.
    function void note_input(logic [7:0] b, logic has, logic eom);
      logic [31:0] n;
      logic [31:0] fix0;
      logic [31:0] fix1;
      digest_out_t e;
      int r;
      int k;
      if (has) begin
        if (bytes_taken >= LEN_LIMIT) length_overflow = 1'b1;
        mix_byte(b);
        bytes_taken = bytes_taken + 32'd1;
      end
      if (!eom) return;

      // Fold in the length, then three rounds of rotate and XOR.
      n = bytes_taken;
      mix[0] = mix[0] ^ n;
      mix[1] = mix[1] + (n << 8);
      mix[2] = mix[2] ^ (n << 16);
      mix[3] = mix[3] + (n << 24);
      mix[4] = mix[4] ^ n;
      for (r = 0; r < 3; r++) begin
        for (k = 0; k < NUM_WORDS; k++) begin
          mix[k] = rotl(mix[k], 11) ^ mix[(k + 1) % NUM_WORDS];
        end
      end

      // The two leading digest bytes get their fixups.
      fix0 = (mix[1] ^ mix[3] ^ mix[4]) & 32'hFF;
      fix1 = ((mix[2] >> 24) ^ (mix[3] >> 8) ^ (mix[4] >> 8)) & 32'hFF;
      mix[0] = mix[0] ^ ((fix0 << 24) | (fix1 << 16));

      for (k = 0; k < NUM_WORDS; k++) begin
        e.word = mix[k];
        e.index = 3'(k);
        e.last = (k == NUM_WORDS - 1);
        e.overlong = length_overflow;
        owed_words.push_back(e);
      end
      restart();
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch: %s", what);
      mismatches++;
    endtask

    // Compares one output transaction with the oldest owed word.
    task check_result(logic [31:0] word, logic [2:0] index, logic last,
                      logic overlong);
      digest_out_t e;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
        return;
      end
      e = owed_words.pop_front();
      if (word !== e.word)
        report_mismatch($sformatf("word %0d: digest_word %h, wanted %h",
                                  e.index, word, e.word));
      if (index !== e.index)
        report_mismatch($sformatf("word_index %0d, wanted %0d", index, e.index));
      if (last !== e.last)
        report_mismatch($sformatf("word %0d: last_word %b, wanted %b",
                                  e.index, last, e.last));
      if (overlong !== e.overlong)
        report_mismatch($sformatf("word %0d: too_long %b, wanted %b",
                                  e.index, overlong, e.overlong));
    endtask

    function int outstanding();
      return owed_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        too_long;

  int               cycle_count = 0;
  int               counted_items = 0;
  bit               no_idle_tx = 1'b1;
  bit               no_idle_rx = 1'b1;
  bit               hold_request = 1'b0;
  logic             hold_off = 1'b0;
  digest_scoreboard sb;

  byte_stream_digest_160_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .too_long       (too_long)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int tx_wait();
    return no_idle_tx ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic int rx_wait();
    return no_idle_rx ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // Offers one input transaction and waits until the block takes it. Valid is
  // left high so that a following transaction with no gap keeps it high.
  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    int gap;
    gap = tx_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= has;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(b, has, eom);
    counted_items++;
  endtask

  // Sends a message of nbytes bytes. The end marker rides on the last byte or
  // follows it alone; noisy messages carry ignored transactions in between.
  task automatic send_message(input int nbytes, input bit byte_on_end, input bit noisy);
    int i;
    for (i = 0; i < nbytes; i++) begin
      if (noisy && $urandom_range(0, 4) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, byte_on_end && (i == nbytes - 1));
    end
    if (!byte_on_end || nbytes == 0) begin
      if (noisy && $urandom_range(0, 2) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // One long output hold-off, counted here while the sender keeps going.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Output side: stall for a drawn number of valid cycles, then take one word.
  initial begin
    int   gap;
    int   seen;
    logic stalled;
    @(posedge clk);
    forever begin
      gap = rx_wait();
      stalled = (gap > 0) || hold_off;
      if (stalled) out_stall <= 1'b1;
      seen = 0;
      while (seen < gap || hold_off) begin
        @(posedge clk);
        if (out_valid === 1'b1) seen++;
      end
      if (stalled) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      sb.check_result(digest_word, word_index, last_word, too_long);
    end
  end

  // Stimulus and end of run.
  initial begin
    int msg;
    int len;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, with a byte on the marker that must be ignored.
    send_item(8'hFF, 1'b0, 1'b1);
    // Single-byte messages at both byte extremes.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // Ignored transaction, two bytes, then an end marker without a byte.
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    // All-ones bytes, end marker carried on the last one.
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    // Alternating bit patterns, then two empty messages back to back.
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h3C, 1'b0, 1'b1);
    // Zero bytes in a row, with the marker on the last.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);

    // Random messages, mostly short, now and then long or noisy.
    msg = 0;
    while (counted_items < TOTAL_ITEMS) begin
      if (msg % 3 == 0) begin
        no_idle_tx = ($urandom_range(0, 3) == 0);
        no_idle_rx = ($urandom_range(0, 3) == 0);
      end
      if (msg == 4) hold_request = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 60))
                                        : int'($urandom_range(0, 10));
      if (len > TOTAL_ITEMS - counted_items) len = TOTAL_ITEMS - counted_items;
      send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      msg++;
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
